FILE: rtl/madt_ep_pkg.sv
package madt_ep_pkg;

   // Capacities of the three record kinds.
   localparam int MAX_PROCESSORS     = 64;
   localparam int MAX_IO_CONTROLLERS = 16;
   localparam int MAX_OVERRIDES      = 16;

   localparam int PCNT_W = $clog2(MAX_PROCESSORS + 1);
   localparam int ICNT_W = $clog2(MAX_IO_CONTROLLERS + 1);
   localparam int OCNT_W = $clog2(MAX_OVERRIDES + 1);

   // The fixed header ahead of the first entry.
   localparam logic [31:0] HEADER_BYTES = 32'd44;

   // Entry type codes.
   localparam logic [7:0] ENTRY_LOCAL_APIC  = 8'd0;
   localparam logic [7:0] ENTRY_IO_APIC     = 8'd1;
   localparam logic [7:0] ENTRY_OVERRIDE    = 8'd2;
   localparam logic [7:0] ENTRY_LAPIC_ADDR  = 8'd5;
   localparam logic [7:0] ENTRY_LOCAL_X2APIC = 8'd9;

   // Flag masks.
   localparam logic [31:0] PROC_ENABLED        = 32'h0000_0001;
   localparam logic [31:0] PROC_ONLINE_CAPABLE = 32'h0000_0002;
   localparam logic [15:0] OVR_POLARITY_MASK   = 16'h0003;
   localparam logic [15:0] OVR_TRIGGER_MASK    = 16'h000C;

   // Output queue.
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_PROCESSOR     = 2'd0,
      KIND_IO_CONTROLLER = 2'd1,
      KIND_OVERRIDE      = 2'd2,
      KIND_SUMMARY       = 2'd3
   } record_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_table;
   } req_type;

   typedef struct packed {
      record_kind_type record_kind;
      logic [5:0]      slot;
      logic [31:0]     ident;
      logic [31:0]     number;
      logic [63:0]     address;
      logic            flag_first;
      logic            flag_second;
      logic            table_ok;
      logic [6:0]      processor_total;
      logic [4:0]      io_controller_total;
      logic [4:0]      override_total;
      logic            last;
   } rsp_type;

   // Records produced by one byte, in order: count is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

FILE: rtl/madt_ep_core.sv
module madt_ep_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  madt_ep_pkg::req_type item,
   output madt_ep_pkg::push_type push
);
   import madt_ep_pkg::*;

   logic [31:0]       pos_ff, pos_in;
   logic [31:0]       dlen_ff, dlen_in;
   logic [7:0]        sum_ff, sum_in;
   logic [63:0]       lca_ff, lca_in;
   logic [31:0]       start_ff, start_in;
   logic              stop_ff, stop_in;
   logic [PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [ICNT_W-1:0] icnt_ff, icnt_in;
   logic [OCNT_W-1:0] ocnt_ff, ocnt_in;
   logic [7:0]        eb_ff [16];

   logic [7:0]  b;
   logic        walking;
   logic [31:0] off;
   logic        off_in_buf;
   logic [7:0]  view [16];
   logic [7:0]  ent_len;
   logic        stop_now;
   logic        finish;
   logic        rec_hit;
   rsp_type     rec;
   rsp_type     summ;
   logic [63:0] lca_new;
   logic [PCNT_W-1:0] pcnt_new;
   logic [ICNT_W-1:0] icnt_new;
   logic [OCNT_W-1:0] ocnt_new;
   logic [31:0] w4, w8, w12;
   logic [15:0] ovr_flags;

   always_comb begin
      b = item.data_byte;

      sum_in = sum_ff;
      if (pos_ff < 32'd8 || pos_ff < dlen_ff) begin
         sum_in = sum_ff + b;
      end

      dlen_in = dlen_ff;
      if (pos_ff >= 32'd4 && pos_ff < 32'd8) begin
         dlen_in[{pos_ff[1:0], 3'b000} +: 8] = dlen_ff[{pos_ff[1:0], 3'b000} +: 8] | b;
      end

      lca_new = lca_ff;
      if (pos_ff >= 32'd36 && pos_ff < 32'd40) begin
         lca_new[{pos_ff[1:0], 3'b000} +: 8] = lca_ff[{pos_ff[1:0], 3'b000} +: 8] | b;
      end

      // Entry walk. The current byte is folded into the entry buffer view
      // so that the length byte and the final body byte are seen at once.
      walking    = !stop_ff && pos_ff >= start_ff && pos_ff < dlen_ff;
      off        = pos_ff - start_ff;
      off_in_buf = walking && (off[31:4] == 28'd0);
      for (int i = 0; i < 16; i++) begin
         view[i] = (off_in_buf && off[3:0] == 4'(i)) ? b : eb_ff[i];
      end
      ent_len  = view[1];
      stop_now = walking && off == 32'd1 &&
                 (b < 8'd2 || ({1'b0, start_ff} + 33'(b)) > {1'b0, dlen_ff});
      finish   = walking && !stop_now && off != 32'd0 &&
                 ({1'b0, off} + 33'd1) == 33'(ent_len);

      w4        = {view[7], view[6], view[5], view[4]};
      w8        = {view[11], view[10], view[9], view[8]};
      w12       = {view[15], view[14], view[13], view[12]};
      ovr_flags = {view[9], view[8]};

      rec      = '0;
      rec_hit  = 1'b0;
      pcnt_new = pcnt_ff;
      icnt_new = icnt_ff;
      ocnt_new = ocnt_ff;
      if (finish) begin
         unique case (view[0])
            ENTRY_LOCAL_APIC: begin
               if (ent_len >= 8'd8 && pcnt_ff < PCNT_W'(MAX_PROCESSORS)) begin
                  rec_hit         = 1'b1;
                  rec.record_kind = KIND_PROCESSOR;
                  rec.slot        = 6'(pcnt_ff);
                  rec.ident       = {24'd0, view[3]};
                  rec.number      = {24'd0, view[2]};
                  rec.flag_first  = (w4 & (PROC_ENABLED | PROC_ONLINE_CAPABLE)) != 32'd0;
                  pcnt_new        = pcnt_ff + 1'b1;
               end
            end
            ENTRY_LOCAL_X2APIC: begin
               if (ent_len >= 8'd16 && pcnt_ff < PCNT_W'(MAX_PROCESSORS)) begin
                  rec_hit         = 1'b1;
                  rec.record_kind = KIND_PROCESSOR;
                  rec.slot        = 6'(pcnt_ff);
                  rec.ident       = w4;
                  rec.number      = w12;
                  rec.flag_first  = (w8 & (PROC_ENABLED | PROC_ONLINE_CAPABLE)) != 32'd0;
                  rec.flag_second = 1'b1;
                  pcnt_new        = pcnt_ff + 1'b1;
               end
            end
            ENTRY_IO_APIC: begin
               if (ent_len >= 8'd12 && icnt_ff < ICNT_W'(MAX_IO_CONTROLLERS)) begin
                  rec_hit         = 1'b1;
                  rec.record_kind = KIND_IO_CONTROLLER;
                  rec.slot        = 6'(icnt_ff);
                  rec.ident       = {24'd0, view[2]};
                  rec.number      = w8;
                  rec.address     = {32'd0, w4};
                  icnt_new        = icnt_ff + 1'b1;
               end
            end
            ENTRY_OVERRIDE: begin
               if (ent_len >= 8'd10 && ocnt_ff < OCNT_W'(MAX_OVERRIDES) &&
                   view[2] == 8'd0) begin
                  rec_hit         = 1'b1;
                  rec.record_kind = KIND_OVERRIDE;
                  rec.slot        = 6'(ocnt_ff);
                  rec.ident       = {24'd0, view[3]};
                  rec.number      = w4;
                  rec.flag_first  = (ovr_flags & OVR_POLARITY_MASK) == OVR_POLARITY_MASK;
                  rec.flag_second = (ovr_flags & OVR_TRIGGER_MASK) == OVR_TRIGGER_MASK;
                  ocnt_new        = ocnt_ff + 1'b1;
               end
            end
            ENTRY_LAPIC_ADDR: begin
               if (ent_len >= 8'd12) begin
                  lca_new = {w8, w4};
               end
            end
            default: begin
            end
         endcase
      end
      rec.last = !item.end_of_table;

      summ                     = '0;
      summ.record_kind         = KIND_SUMMARY;
      summ.address             = lca_new;
      summ.table_ok            = sum_in == 8'd0 && dlen_in >= HEADER_BYTES &&
                                 ({1'b0, pos_ff} + 33'd1) >= {1'b0, dlen_in};
      summ.processor_total     = 7'(pcnt_new);
      summ.io_controller_total = 5'(icnt_new);
      summ.override_total      = 5'(ocnt_new);
      summ.last                = 1'b1;

      push.first  = rec_hit ? rec : summ;
      push.second = summ;
      push.count  = item_valid ? ({1'b0, rec_hit} + {1'b0, item.end_of_table}) : 2'd0;

      pos_in   = (pos_ff == 32'hFFFF_FFFF) ? pos_ff : pos_ff + 32'd1;
      lca_in   = lca_new;
      start_in = finish ? start_ff + 32'(ent_len) : start_ff;
      stop_in  = stop_ff | stop_now;
      pcnt_in  = pcnt_new;
      icnt_in  = icnt_new;
      ocnt_in  = ocnt_new;
   end

   always_ff @(posedge clock) begin
      if (reset || (item_valid && item.end_of_table)) begin
         pos_ff   <= '0;
         dlen_ff  <= '0;
         sum_ff   <= '0;
         lca_ff   <= '0;
         start_ff <= HEADER_BYTES;
         stop_ff  <= 1'b0;
         pcnt_ff  <= '0;
         icnt_ff  <= '0;
         ocnt_ff  <= '0;
      end else if (item_valid) begin
         pos_ff   <= pos_in;
         dlen_ff  <= dlen_in;
         sum_ff   <= sum_in;
         lca_ff   <= lca_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         pcnt_ff  <= pcnt_in;
         icnt_ff  <= icnt_in;
         ocnt_ff  <= ocnt_in;
      end
   end

   // Entry buffer holds only the first sixteen bytes of the current entry.
   always_ff @(posedge clock) begin
      if (item_valid && off_in_buf) begin
         eb_ff[off[3:0]] <= b;
      end
   end

endmodule

FILE: rtl/madt_ep_outq.sv
module madt_ep_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  madt_ep_pkg::push_type push,
   output logic                 space_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output madt_ep_pkg::rsp_type rsp_data
);
   import madt_ep_pkg::*;

   rsp_type               q_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ff, wr_in;
   logic [OUTQ_PTR_W-1:0] rd_ff, rd_in;
   logic [OUTQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  pop;
   logic [OUTQ_PTR_W-1:0] wr_next;

   always_comb begin
      rsp_valid = cnt_ff != '0;
      rsp_data  = q_ff[rd_ff];
      pop       = rsp_valid && rsp_ready;
      // Room for the two transactions a single byte can cause.
      space_ok  = cnt_ff <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
      wr_next   = wr_ff + 1'b1;
      wr_in     = wr_ff + OUTQ_PTR_W'(push.count);
      rd_in     = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in    = cnt_ff + OUTQ_CNT_W'(push.count) - OUTQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.second;
      end
   end

endmodule

FILE: rtl/madt_entry_stream_parser_unit.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data  (one table byte, end mark)
// rsp       out        rsp_valid / rsp_ready  rsp_data  (one record or summary)
//
// One byte is taken per cycle when the output side keeps up. An accepted byte
// waits in the input register until the queue has room, and its records are then
// written into a four-entry output queue, from which they show on rsp. A byte that
// completes an entry and also ends the table causes two transactions on the rsp
// port. Reset is synchronous and empties the queue; no clearing pass is needed. A
// stall on rsp fills the queue, and req_ready drops once fewer than two queue
// entries are free.
module madt_entry_stream_parser_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  madt_ep_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output madt_ep_pkg::rsp_type rsp_data
);
   import madt_ep_pkg::*;

   // Input register: holds one accepted byte until the parser consumes it.
   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     space_ok;
   logic     fire;
   push_type push;

   // The parser consumes the held byte whenever the queue can take the up to
   // two transactions that it may cause. A new byte enters in the same cycle.
   always_comb begin
      fire        = in_valid_ff && space_ok;
      req_ready   = !in_valid_ff || fire;
      in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Header capture, checksum, entry walk and record building.
   madt_ep_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (fire),
      .item       (in_data_ff),
      .push       (push)
   );

   // Result registers that part the parser from the rsp side.
   madt_ep_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/madt_ep_checker.sv
module madt_ep_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input madt_ep_pkg::req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input madt_ep_pkg::rsp_type rsp_data
);
   import madt_ep_pkg::*;

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // A stalled request transaction holds its payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req payload changed while stalled");

   // A summary always closes the results of its byte.
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_kind == KIND_SUMMARY |-> rsp_data.last)
      else $error("summary without last");

   // A record that is not last has its summary queued right behind it.
   a_summary_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("summary missing after record");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind madt_entry_stream_parser_unit madt_ep_checker u_madt_ep_checker (.*);
